@@ design/blm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the battery level monitor: field widths, register indexes,
// configuration record and the batch record passed from front to back.
// No dependencies.
package blm_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int SUM_W       = 18;
	localparam int COUNT_W     = 6;
	localparam int FILT_W      = 26;
	localparam int TIME_W      = 32;
	localparam int PCT_W       = 7;
	localparam int WEIGHT_W    = 16;
	localparam int SCALE_W     = 24;
	localparam int IVAL_W      = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [SUM_W-1:0] SUM_MAX     = {SUM_W{1'b1}};
	localparam logic [PCT_W-1:0] PERCENT_MAX = PCT_W'(100);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BATCH_LENGTH  = 3'd0,
		REG_FILTER_WEIGHT = 3'd1,
		REG_INIT_LEVEL    = 3'd2,
		REG_EMPTY_LEVEL   = 3'd3,
		REG_FULL_LEVEL    = 3'd4,
		REG_PERCENT_SCALE = 3'd5,
		REG_REPORT_IVAL   = 3'd6,
		REG_HYSTERESIS    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0]  batch_length;
		logic [WEIGHT_W-1:0] filter_weight;
		logic [SUM_W-1:0]    init_level;
		logic [SUM_W-1:0]    empty_level;
		logic [SUM_W-1:0]    full_level;
		logic [SCALE_W-1:0]  percent_scale;
		logic [IVAL_W-1:0]   report_interval_ms;
		logic [PCT_W-1:0]    percent_hysteresis;
	} cfg_t;

	// One finished batch: its sum and the time of its last sample.
	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [TIME_W-1:0] now;
	} batch_t;

endpackage

@@ design/blm_front.sv @@
`timescale 1ns / 1ps
// Front end: accumulates ADC samples into a batch and pushes each finished
// batch to the queue. Depends on blm_pkg.
module blm_front import blm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   queue_full,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   sample_ok,
	input  logic [TIME_W-1:0]      now_ms,
	input  logic [COUNT_W-1:0]     batch_length,
	output logic                   in_stall,
	output logic                   push,
	output batch_t                 push_data
);

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] count_next;
	logic [COUNT_W-1:0] need;
	logic               accept;
	logic               batch_done;

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_comb begin
		sum_wide = {1'b0, sum_q} + (SUM_W+1)'(adc_sample);
		if (!sample_ok) begin
			sum_next = sum_q;
		end else if (sum_wide[SUM_W]) begin
			sum_next = SUM_MAX;
		end else begin
			sum_next = sum_wide[SUM_W-1:0];
		end
		count_next = count_q + COUNT_W'(1);
		need       = (batch_length == '0) ? COUNT_W'(1) : batch_length;
		// count wrapping to zero also closes the batch
		batch_done = (count_next == '0) || (count_next >= need);
	end

	assign push           = accept && batch_done;
	assign push_data.sum  = sum_next;
	assign push_data.now  = now_ms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (batch_done) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_next;
			end
		end
	end

endmodule

@@ design/blm_queue.sv @@
`timescale 1ns / 1ps
// Short queue of finished batches between front and back end.
// Depends on blm_pkg.
module blm_queue import blm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  batch_t push_data,
	input  logic   pop,
	output logic   full,
	output logic   empty,
	output batch_t pop_data
);

	batch_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/blm_back.sv @@
`timescale 1ns / 1ps
// Back end: filter update, report timing, percent and hysteresis, output
// register. Depends on blm_pkg.
module blm_back import blm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              queue_empty,
	input  batch_t            queue_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SUM_W-1:0]  filtered_level,
	output logic [PCT_W-1:0]  shown_percent,
	output logic              reported
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_BLEND = 5'b00100,
		ST_PCT   = 5'b01000,
		ST_DONE  = 5'b10000
	} back_state_t;

	localparam int PA_W = WEIGHT_W + FILT_W;
	localparam int PB_W = WEIGHT_W + 1 + FILT_W;
	localparam int PP_W = FILT_W + SCALE_W;

	back_state_t        state_q;
	batch_t             batch_s1;
	logic [PA_W-1:0]    prod_a_s2;
	logic [PB_W-1:0]    prod_b_s2;
	logic               seed_s2;
	logic [PP_W-1:0]    prod_p_s4;
	logic               below_s4;
	logic               above_s4;
	logic               rep_q;
	logic [FILT_W-1:0]  filt_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [PCT_W-1:0]   shown_q;
	logic               out_valid_q;
	logic [SUM_W-1:0]   out_level_q;
	logic [PCT_W-1:0]   out_pct_q;
	logic               out_rep_q;

	logic [FILT_W-1:0]   sum8;
	logic [WEIGHT_W:0]   inv_weight;
	logic [PB_W:0]       blend_sum;
	logic [TIME_W-1:0]   elapsed;
	logic [FILT_W-1:0]   empty8;
	logic [FILT_W-1:0]   full8;
	logic [PP_W-TIME_W-1:0] pct_raw;
	logic [PCT_W-1:0]    pct;
	logic [PCT_W-1:0]    pct_diff;
	logic [PCT_W-1:0]    shown_next;
	logic                out_free;

	always_comb begin
		sum8       = {batch_s1.sum, 8'd0};
		inv_weight = (WEIGHT_W+1)'(1 << WEIGHT_W) - (WEIGHT_W+1)'(cfg.filter_weight);
		blend_sum  = (PB_W+1)'(prod_a_s2) + (PB_W+1)'(prod_b_s2);
		elapsed    = batch_s1.now - last_time_q;
		empty8     = {cfg.empty_level, 8'd0};
		full8      = {cfg.full_level, 8'd0};
		pct_raw    = prod_p_s4[PP_W-1:TIME_W];
		if (below_s4) begin
			pct = '0;
		end else if (above_s4 || pct_raw > (PP_W-TIME_W)'(PERCENT_MAX)) begin
			pct = PERCENT_MAX;
		end else begin
			pct = pct_raw[PCT_W-1:0];
		end
		pct_diff = (pct > shown_q) ? pct - shown_q : shown_q - pct;
		shown_next = (rep_q && pct_diff >= cfg.percent_hysteresis) ? pct : shown_q;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && !queue_empty;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				batch_s1 <= queue_data;
			end
			ST_MUL: begin
				prod_a_s2 <= PA_W'(cfg.filter_weight) * PA_W'(sum8);
				prod_b_s2 <= PB_W'(inv_weight) * PB_W'(filt_q);
				seed_s2   <= filt_q < {cfg.init_level, 8'd0};
			end
			ST_PCT: begin
				prod_p_s4 <= PP_W'(filt_q - empty8) * PP_W'(cfg.percent_scale);
				below_s4  <= filt_q <= empty8;
				above_s4  <= filt_q >= full8;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			out_level_q <= filt_q[FILT_W-1:8];
			out_pct_q   <= shown_next;
			out_rep_q   <= rep_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			filt_q      <= '0;
			last_time_q <= '0;
			shown_q     <= '0;
			rep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// in ST_DONE the output register is reloaded below instead
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					filt_q <= seed_s2 ? sum8 : blend_sum[WEIGHT_W +: FILT_W];
					rep_q  <= elapsed > TIME_W'(cfg.report_interval_ms);
					if (elapsed > TIME_W'(cfg.report_interval_ms)) begin
						last_time_q <= batch_s1.now;
					end
					state_q <= ST_PCT;
				end
				ST_PCT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						shown_q     <= shown_next;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_level = out_level_q;
	assign shown_percent  = out_pct_q;
	assign reported       = out_rep_q;

endmodule

@@ design/battery_level_monitor.sv @@
`timescale 1ns / 1ps
// Battery level monitor. The sample that closes a batch passes the queue entry, batch_s1,
// the product registers, filt_q, prod_p_s4 and the output register, waiting while an
// earlier batch or out_stall holds. Throughput: one sample per cycle while the 2-deep
// batch queue has room; the back end takes batches one at a time (dequeue, multiply,
// blend, percent multiply, hysteresis), so short batches fill the queue and raise in_stall.
// Reset returns config to defaults and clears filter, timing and accumulation state.
module battery_level_monitor import blm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] adc_sample,
	input  logic                   sample_ok,
	input  logic [TIME_W-1:0]      now_ms,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [SUM_W-1:0]       filtered_level,
	output logic [PCT_W-1:0]       shown_percent,
	output logic                   reported,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t   cfg_q;
	logic   push;
	batch_t push_data;
	logic   pop;
	logic   queue_full;
	logic   queue_empty;
	batch_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.batch_length       <= COUNT_W'(30);
			cfg_q.filter_weight      <= WEIGHT_W'(3277);
			cfg_q.init_level         <= SUM_W'(3384);
			cfg_q.empty_level        <= SUM_W'(32489);
			cfg_q.full_level         <= SUM_W'(41966);
			cfg_q.percent_scale      <= SCALE_W'(177030);
			cfg_q.report_interval_ms <= IVAL_W'(1000);
			cfg_q.percent_hysteresis <= PCT_W'(2);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BATCH_LENGTH:  cfg_q.batch_length       <= cfg_data[COUNT_W-1:0];
				REG_FILTER_WEIGHT: cfg_q.filter_weight      <= cfg_data[WEIGHT_W-1:0];
				REG_INIT_LEVEL:    cfg_q.init_level         <= cfg_data[SUM_W-1:0];
				REG_EMPTY_LEVEL:   cfg_q.empty_level        <= cfg_data[SUM_W-1:0];
				REG_FULL_LEVEL:    cfg_q.full_level         <= cfg_data[SUM_W-1:0];
				REG_PERCENT_SCALE: cfg_q.percent_scale      <= cfg_data[SCALE_W-1:0];
				REG_REPORT_IVAL:   cfg_q.report_interval_ms <= cfg_data[IVAL_W-1:0];
				REG_HYSTERESIS:    cfg_q.percent_hysteresis <= cfg_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	blm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.queue_full   (queue_full),
		.adc_sample   (adc_sample),
		.sample_ok    (sample_ok),
		.now_ms       (now_ms),
		.batch_length (cfg_q.batch_length),
		.in_stall     (in_stall),
		.push         (push),
		.push_data    (push_data)
	);

	blm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (queue_full),
		.empty     (queue_empty),
		.pop_data  (pop_data)
	);

	blm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.queue_empty    (queue_empty),
		.queue_data     (pop_data),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_level (filtered_level),
		.shown_percent  (shown_percent),
		.reported       (reported)
	);

endmodule

@@ design/blm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for battery_level_monitor, bound to the top level.
// Depends on blm_pkg.
module blm_checker import blm_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [SUM_W-1:0]       filtered_level,
	input logic [PCT_W-1:0]       shown_percent,
	input logic                   reported
);

	// last delivered percent; zero after reset like the shown value
	logic [PCT_W-1:0] prev_shown_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_shown_q <= '0;
		end else if (out_valid && !out_stall) begin
			prev_shown_q <= shown_percent;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(filtered_level)
			&& $stable(shown_percent) && $stable(reported))
		else $error("output transaction changed while stalled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shown_percent <= PERCENT_MAX)
		else $error("shown percent above 100");

	a_no_report_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reported |-> shown_percent == prev_shown_q)
		else $error("shown percent changed without a report");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for battery_level_monitor: a directed table followed by random phases, each
// result transaction checked against its typed row or a local model of the batch sum,
// filter and percent logic. Depends on blm_pkg and the battery_level_monitor RTL.
module tb_top;
	import blm_pkg::*;

	localparam int SETTLE      = 12;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		logic [SUM_W-1:0] level;
		logic [PCT_W-1:0] percent;
		logic             rep;
	} gauge_result_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic                   ok;
		logic [TIME_W-1:0]      t;
		logic                   typed;
		gauge_result_t          want;
	} row_t;

	// Seeded directly, then blended at half weight; empty 1000, full 3000.
	localparam cfg_t DIRECTED_REGS = '{
		batch_length: '0, filter_weight: 16'd32768, init_level: 18'd100,
		empty_level: 18'd1000, full_level: 18'd3000, percent_scale: 24'd838860,
		report_interval_ms: 16'd1000, percent_hysteresis: 7'd2
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [SAMPLE_BITS-1:0] adc_sample;
	logic                   sample_ok;
	logic [TIME_W-1:0]      now_ms;
	logic                   out_valid;
	logic                   out_stall;
	logic [SUM_W-1:0]       filtered_level;
	logic [PCT_W-1:0]       shown_percent;
	logic                   reported;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Typed expectation travels with the offered sample.
	logic          row_typed;
	gauge_result_t row_want;
	logic          hold_req;
	logic          rx_quiet;
	logic [TIME_W-1:0] ms_clock;
	int            mismatches = 0;

	// Model state
	cfg_t               gauge_cfg;
	logic [SUM_W-1:0]   acc_sum;
	logic [COUNT_W-1:0] acc_count;
	logic [FILT_W-1:0]  filt_q8;
	logic [TIME_W-1:0]  last_rep_ms;
	logic [PCT_W-1:0]   pct_shown;
	gauge_result_t      pending_readings[$];

	row_t dir_rows [0:13] = '{
		'{12'd0,    1'b1, 32'd0,          1'b1, '{18'd0,    7'd0,   1'b0}},
		// failed conversion adds zero; interval just exceeded
		'{12'd4095, 1'b0, 32'd1001,       1'b1, '{18'd0,    7'd0,   1'b1}},
		'{12'd4095, 1'b1, 32'd1001,       1'b1, '{18'd4095, 7'd0,   1'b0}},
		'{12'd4095, 1'b1, 32'hFFFF_FFFF,  1'b1, '{18'd4095, 7'd100, 1'b1}},
		// time wrapped: only 6 ms elapsed
		'{12'd4095, 1'b1, 32'd5,          1'b1, '{18'd4095, 7'd100, 1'b0}},
		'{12'd0,    1'b1, 32'd1006,       1'b0, '0},
		'{12'h555,  1'b1, 32'd1006,       1'b0, '0},
		'{12'hAAA,  1'b1, 32'd2100,       1'b0, '0},
		'{12'hAAA,  1'b0, 32'd3200,       1'b0, '0},
		'{12'hFFF,  1'b1, 32'd4300,       1'b0, '0},
		'{12'h800,  1'b1, 32'd4300,       1'b0, '0},
		'{12'h7FF,  1'b1, 32'd5400,       1'b0, '0},
		'{12'h001,  1'b1, 32'd6500,       1'b0, '0},
		'{12'hFFE,  1'b1, 32'h8000_0000,  1'b0, '0}
	};

	battery_level_monitor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.adc_sample     (adc_sample),
		.sample_ok      (sample_ok),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_level (filtered_level),
		.shown_percent  (shown_percent),
		.reported       (reported),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Returns 1 when the sample closes a batch; r then holds the reading.
	function automatic bit gauge_update(input logic [SAMPLE_BITS-1:0] smp, input logic ok,
		input logic [TIME_W-1:0] t, output gauge_result_t r);
		logic [COUNT_W-1:0] need;
		logic [SUM_W:0]     wide_sum;
		logic [63:0]        sum8, w, f, lo, hi, pct, diff;
		logic [TIME_W-1:0]  elapsed;
		bit                 rep;
		r = '0;
		rep = 1'b0;
		need = (gauge_cfg.batch_length == 0) ? COUNT_W'(1) : gauge_cfg.batch_length;
		if (ok) begin
			wide_sum = {1'b0, acc_sum} + (SUM_W+1)'(smp);
			acc_sum = (wide_sum > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : wide_sum[SUM_W-1:0];
		end
		acc_count = acc_count + COUNT_W'(1);
		if (acc_count < need && acc_count != 0)
			return 1'b0;

		sum8 = 64'(acc_sum) << 8;
		if (64'(filt_q8) < (64'(gauge_cfg.init_level) << 8)) begin
			filt_q8 = FILT_W'(sum8);
		end else begin
			w = 64'(gauge_cfg.filter_weight);
			filt_q8 = FILT_W'((w * sum8 + (64'd65536 - w) * 64'(filt_q8)) >> 16);
		end
		acc_sum = '0;
		acc_count = '0;

		elapsed = t - last_rep_ms;
		if (elapsed > TIME_W'(gauge_cfg.report_interval_ms)) begin
			rep = 1'b1;
			last_rep_ms = t;
			f = 64'(filt_q8);
			lo = 64'(gauge_cfg.empty_level) << 8;
			hi = 64'(gauge_cfg.full_level) << 8;
			if (f <= lo)
				pct = 0;
			else if (f >= hi)
				pct = 100;
			else begin
				pct = ((f - lo) * 64'(gauge_cfg.percent_scale)) >> 32;
				if (pct > 100)
					pct = 100;
			end
			diff = (pct > 64'(pct_shown)) ? pct - 64'(pct_shown) : 64'(pct_shown) - pct;
			if (diff >= 64'(gauge_cfg.percent_hysteresis))
				pct_shown = PCT_W'(pct);
		end
		r.level = SUM_W'(filt_q8 >> 8);
		r.percent = pct_shown;
		r.rep = rep;
		return 1'b1;
	endfunction

	// Checker and model: result transactions first, then register writes, then samples.
	always @(posedge clk or negedge arst_n) begin
		gauge_result_t got, want, reading;
		if (!arst_n) begin
			gauge_cfg = '{
				batch_length: 6'd30, filter_weight: 16'd3277, init_level: 18'd3384,
				empty_level: 18'd32489, full_level: 18'd41966, percent_scale: 24'd177030,
				report_interval_ms: 16'd1000, percent_hysteresis: 7'd2
			};
			acc_sum = '0;
			acc_count = '0;
			filt_q8 = '0;
			last_rep_ms = '0;
			pct_shown = '0;
			pending_readings.delete();
		end else begin
			if (out_valid && !out_stall) begin
				got = '{filtered_level, shown_percent, reported};
				if (pending_readings.size() == 0) begin
					$error("unexpected result transaction: level %0d percent %0d reported %0b",
						got.level, got.percent, got.rep);
					mismatches++;
				end else begin
					want = pending_readings.pop_front();
					if (got.level !== want.level) begin
						$error("filtered_level: expected %0d, got %0d", want.level, got.level);
						mismatches++;
					end
					if (got.percent !== want.percent) begin
						$error("shown_percent: expected %0d, got %0d", want.percent, got.percent);
						mismatches++;
					end
					if (got.rep !== want.rep) begin
						$error("reported: expected %0b, got %0b", want.rep, got.rep);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BATCH_LENGTH:  gauge_cfg.batch_length = cfg_data[COUNT_W-1:0];
					REG_FILTER_WEIGHT: gauge_cfg.filter_weight = cfg_data[WEIGHT_W-1:0];
					REG_INIT_LEVEL:    gauge_cfg.init_level = cfg_data[SUM_W-1:0];
					REG_EMPTY_LEVEL:   gauge_cfg.empty_level = cfg_data[SUM_W-1:0];
					REG_FULL_LEVEL:    gauge_cfg.full_level = cfg_data[SUM_W-1:0];
					REG_PERCENT_SCALE: gauge_cfg.percent_scale = cfg_data[SCALE_W-1:0];
					REG_REPORT_IVAL:   gauge_cfg.report_interval_ms = cfg_data[IVAL_W-1:0];
					REG_HYSTERESIS:    gauge_cfg.percent_hysteresis = cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (gauge_update(adc_sample, sample_ok, now_ms, reading))
					pending_readings.push_back(row_typed ? row_want : reading);
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		int  r, len;
		bit  hold_done;
		hold_done = 1'b0;
		out_stall = 1'b0;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				len = HOLD_CYCLES;
				hold_done = 1'b1;
			end else if (rx_quiet || r < 65) begin
				out_stall <= 1'b0;
				len = $urandom_range(1, 4);
			end else if (r < 95) begin
				out_stall <= 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b1;
				len = $urandom_range(10, 40);
			end
			repeat (len) @(posedge clk);
		end
	end

	task automatic write_config(input cfg_t c);
		cfg_reg_t r;
		r = r.first();
		do begin
			cfg_we <= 1'b1;
			cfg_index <= r;
			case (r)
				REG_BATCH_LENGTH:  cfg_data <= CFG_DATA_W'(c.batch_length);
				REG_FILTER_WEIGHT: cfg_data <= CFG_DATA_W'(c.filter_weight);
				REG_INIT_LEVEL:    cfg_data <= CFG_DATA_W'(c.init_level);
				REG_EMPTY_LEVEL:   cfg_data <= CFG_DATA_W'(c.empty_level);
				REG_FULL_LEVEL:    cfg_data <= CFG_DATA_W'(c.full_level);
				REG_PERCENT_SCALE: cfg_data <= CFG_DATA_W'(c.percent_scale);
				REG_REPORT_IVAL:   cfg_data <= CFG_DATA_W'(c.report_interval_ms);
				default:           cfg_data <= CFG_DATA_W'(c.percent_hysteresis);
			endcase
			@(posedge clk);
			r = r.next();
		end while (r != r.first());
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic ok,
		input logic [TIME_W-1:0] t, input logic typed, input gauge_result_t want);
		in_valid <= 1'b1;
		adc_sample <= smp;
		sample_ok <= ok;
		now_ms <= t;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (in_stall);
	endtask

	// Called right after a transaction; drops valid for a random gap or at phase end.
	task automatic pace(input bit last, input bit no_gaps);
		int r, gap;
		r = $urandom_range(0, 99);
		if (last)
			gap = 0;
		else if (no_gaps || r < 60)
			gap = 0;
		else if (r < 92)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		if (last || gap != 0)
			in_valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic wait_idle(input int settle);
		int n;
		n = 0;
		while (pending_readings.size() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		if (pending_readings.size() != 0) begin
			$error("%0d result transactions never arrived", pending_readings.size());
			mismatches++;
			pending_readings.delete();
		end
		repeat (settle) @(posedge clk);
	endtask

	// Levels are placed around the batch sum that the sample mean will produce.
	function automatic cfg_t rand_config(input int mean);
		cfg_t   c;
		int     need, center, lo, hi, span, r;
		longint sc;
		r = $urandom_range(0, 9);
		if (r == 0)
			c.batch_length = '0;
		else if (r <= 5)
			c.batch_length = COUNT_W'($urandom_range(1, 6));
		else if (r <= 8)
			c.batch_length = COUNT_W'($urandom_range(7, 62));
		else
			c.batch_length = '1;
		need = (c.batch_length == 0) ? 1 : int'(c.batch_length);

		r = $urandom_range(0, 3);
		c.filter_weight = (r == 0) ? '0 : (r == 1) ? '1 : WEIGHT_W'($urandom_range(0, 65535));

		center = need * mean;
		lo = center - int'($urandom_range(0, center / 4 + 50));
		if (lo < 0)
			lo = 0;
		span = int'($urandom_range(1, center / 2 + 200));
		hi = lo + span;
		if (hi > int'(SUM_MAX))
			hi = int'(SUM_MAX);
		if ($urandom_range(0, 9) == 0) begin
			c.empty_level = SUM_W'(hi);
			c.full_level = SUM_W'(lo);
		end else begin
			c.empty_level = SUM_W'(lo);
			c.full_level = SUM_W'(hi);
		end

		sc = (longint'(100) << 24) / span;
		r = $urandom_range(0, 9);
		if (r < 7)
			c.percent_scale = (sc > 64'hFF_FFFF) ? '1 : SCALE_W'(sc);
		else if (r < 9)
			c.percent_scale = SCALE_W'($urandom());
		else
			c.percent_scale = '1;

		r = $urandom_range(0, 3);
		c.init_level = (r == 0) ? '0 : (r == 1) ? '1 : SUM_W'($urandom_range(0, center));

		r = $urandom_range(0, 9);
		c.report_interval_ms = (r == 0) ? '0 : (r == 1) ? '1 : IVAL_W'($urandom_range(1, 200));

		r = $urandom_range(0, 9);
		if (r < 7)
			c.percent_hysteresis = PCT_W'($urandom_range(0, 5));
		else if (r == 7)
			c.percent_hysteresis = PERCENT_MAX;
		else if (r == 8)
			c.percent_hysteresis = '1;
		else
			c.percent_hysteresis = PCT_W'($urandom_range(0, 127));
		return c;
	endfunction

	task automatic run_phase(input cfg_t c, input int mean, input int n_items, input bit no_gaps);
		int spread, step_max, v;
		spread = $urandom_range(0, 500);
		step_max = int'(c.report_interval_ms) / 4 + 2;
		rx_quiet <= no_gaps;
		write_config(c);
		for (int k = 0; k < n_items; k++) begin
			if ($urandom_range(0, 99) < 3)
				ms_clock = $urandom();
			else
				ms_clock += TIME_W'($urandom_range(0, step_max));
			if ($urandom_range(0, 4) == 0)
				v = $urandom_range(0, 4095);
			else
				v = mean + int'($urandom_range(0, 2 * spread)) - spread;
			if (v < 0)
				v = 0;
			else if (v > 4095)
				v = 4095;
			send_sample(SAMPLE_BITS'(v), $urandom_range(0, 9) != 0, ms_clock, 1'b0, '0);
			pace(k == n_items - 1, no_gaps);
		end
		wait_idle(SETTLE);
	endtask

	initial begin
		cfg_t c;
		int   mean;
		arst_n = 1'b0;
		in_valid = 1'b0;
		adc_sample = '0;
		sample_ok = 1'b0;
		now_ms = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BATCH_LENGTH;
		cfg_data = '0;
		row_typed = 1'b0;
		row_want = '0;
		hold_req = 1'b0;
		rx_quiet = 1'b0;
		ms_clock = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_config(DIRECTED_REGS);
		foreach (dir_rows[i]) begin
			send_sample(dir_rows[i].smp, dir_rows[i].ok, dir_rows[i].t, dir_rows[i].typed,
				dir_rows[i].want);
			pace(i == $size(dir_rows) - 1, 1'b0);
		end
		wait_idle(SETTLE);

		ms_clock = $urandom();
		// All registers at their maximum: a long batch left open on purpose.
		run_phase('{default: '1}, $urandom_range(0, 4095), 40, 1'b0);
		// All zero: the open batch closes on the next sample, weight zero holds the filter.
		run_phase('0, $urandom_range(0, 4095), 60, 1'b0);

		// Back pressure: one sample per batch while the receiver holds off.
		mean = $urandom_range(0, 4095);
		c = rand_config(mean);
		c.batch_length = COUNT_W'(1);
		hold_req <= 1'b1;
		run_phase(c, mean, 150, 1'b1);

		repeat (12) begin
			mean = $urandom_range(0, 4095);
			run_phase(rand_config(mean), mean, 100, $urandom_range(0, 3) == 0);
		end

		wait_idle(20);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/blm_pkg.sv
design/blm_front.sv
design/blm_queue.sv
design/blm_back.sv
design/battery_level_monitor.sv
design/blm_checker.sv
verif/tb_top.sv
